[hdl/m3i_pkg.sv]
// Shared constants and index helper for the 3x3 matrix inverse.
`default_nettype none
package m3i_pkg;
	localparam int DIM = 3;
	localparam int NUM_ELEM = DIM * DIM;

	function automatic int idx(input int r, input int c);
		return r * DIM + c;
	endfunction
endpackage
`default_nettype wire

[hdl/m3i_cof.sv]
// Cofactor unit: eighteen registered products, then nine registered differences.
`default_nettype none
module m3i_cof import m3i_pkg::*; #(
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic signed [ELEM_WIDTH-1:0]   a [NUM_ELEM],
	output logic signed [2*ELEM_WIDTH:0]        cof [NUM_ELEM]
);
	localparam int W  = ELEM_WIDTH;
	localparam int PW = 2 * W;
	localparam int CW = 2 * W + 1;

	genvar r, c;
	generate
		for (r = 0; r < DIM; r++) begin : g_row
			for (c = 0; c < DIM; c++) begin : g_col
				localparam int R1 = (r + 1) % DIM;
				localparam int R2 = (r + 2) % DIM;
				localparam int C1 = (c + 1) % DIM;
				localparam int C2 = (c + 2) % DIM;
				logic signed [PW-1:0] p1_s1, p2_s1;

				always_ff @(posedge clk) begin
					p1_s1 <= a[idx(R1, C1)] * a[idx(R2, C2)];
					p2_s1 <= a[idx(R1, C2)] * a[idx(R2, C1)];
				end

				always_ff @(posedge clk) begin
					cof[idx(r, c)] <= CW'(p1_s1) - CW'(p2_s1);
				end
			end
		end
	endgenerate
endmodule
`default_nettype wire

[hdl/m3i_div_lane.sv]
// Division lane: restoring quotient one bit a stage, then rounding and saturation.
`default_nettype none
module m3i_div_lane #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic [2*ELEM_WIDTH:0]         num_mag,
	input  wire logic                          neg,
	input  wire logic [3*ELEM_WIDTH+2:0]       den_mag,
	output logic signed [ELEM_WIDTH-1:0]       res,
	output logic                               ovf
);
	localparam int W   = ELEM_WIDTH;
	localparam int CW  = 2 * W + 1;
	localparam int DW  = 3 * W + 3;
	localparam int NW  = CW + 2 * FRAC_BITS;
	localparam int QB  = W + 1;
	localparam int RWA = (NW > DW + QB) ? NW : DW + QB;
	localparam int RW  = RWA + 1;

	logic [RW-1:0] rem_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic          neg_s [QB+1];
	logic          sat_s [QB+1];

	logic [RW-1:0] num_w;
	logic [RW-1:0] den_top;

	assign num_w   = RW'(num_mag) << (2 * FRAC_BITS);
	assign den_top = RW'(den_mag) << QB;

	always_ff @(posedge clk) begin
		rem_s[0] <= num_w;
		den_s[0] <= den_mag;
		quo_s[0] <= '0;
		neg_s[0] <= neg;
		sat_s[0] <= (num_w >= den_top);
	end

	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_stage
			localparam int SH = QB - 1 - k;
			logic [RW-1:0] dsh;
			logic          ge;

			assign dsh = RW'(den_s[k]) << SH;
			assign ge  = (rem_s[k] >= dsh);

			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? (rem_s[k] - dsh) : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
				neg_s[k+1] <= neg_s[k];
				sat_s[k+1] <= sat_s[k];
			end
		end
	endgenerate

	logic [DW:0]   rem2;
	logic          rnd;
	logic [W+1:0]  q;
	logic [W+1:0]  lim;
	logic [W+1:0]  mag;
	logic [W+1:0]  sgn;
	logic          big;

	always_comb begin
		rem2 = {rem_s[QB][DW-1:0], 1'b0};
		rnd  = (rem2 >= {1'b0, den_s[QB]});
		q    = (W+2)'(quo_s[QB]) + (W+2)'(rnd);
		lim  = neg_s[QB] ? ((W+2)'(1) << (W - 1)) : (((W+2)'(1) << (W - 1)) - (W+2)'(1));
		big  = sat_s[QB] | (q > lim);
		mag  = big ? lim : q;
		sgn  = neg_s[QB] ? ((W+2)'(0) - mag) : mag;
	end

	always_ff @(posedge clk) begin
		res <= $signed(sgn[W-1:0]);
		ovf <= big;
	end
endmodule
`default_nettype wire

[hdl/mat3_inverse.sv]
// Top level: 3x3 matrix inverse by adjugate over determinant, fully pipelined.
//
// Input channel: nine signed elements a_rXcY, taken at a rising edge with
// start high and busy low. busy is always low: a new matrix may enter every
// cycle, one matrix per cycle sustained.
// Output channel: inv_rXcY, singular and overflow, shown for one cycle with
// done high. The receiver cannot stall; no backpressure exists.
// Pipeline from accept to done: five stages for cofactors, determinant and
// magnitudes, ELEM_WIDTH + 3 in each of nine parallel division lanes (one
// quotient bit per stage), and one merge stage that applies the identity on a
// zero determinant and ORs the lane overflow flags.
// Reset: clears the pipeline valid chain only; no item is in flight after.
`default_nettype none
module mat3_inverse import m3i_pkg::*; #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic signed [ELEM_WIDTH-1:0] a_r0c0,
	input  wire logic signed [ELEM_WIDTH-1:0] a_r0c1,
	input  wire logic signed [ELEM_WIDTH-1:0] a_r0c2,
	input  wire logic signed [ELEM_WIDTH-1:0] a_r1c0,
	input  wire logic signed [ELEM_WIDTH-1:0] a_r1c1,
	input  wire logic signed [ELEM_WIDTH-1:0] a_r1c2,
	input  wire logic signed [ELEM_WIDTH-1:0] a_r2c0,
	input  wire logic signed [ELEM_WIDTH-1:0] a_r2c1,
	input  wire logic signed [ELEM_WIDTH-1:0] a_r2c2,
	output logic                             done,
	output logic signed [ELEM_WIDTH-1:0]     inv_r0c0,
	output logic signed [ELEM_WIDTH-1:0]     inv_r0c1,
	output logic signed [ELEM_WIDTH-1:0]     inv_r0c2,
	output logic signed [ELEM_WIDTH-1:0]     inv_r1c0,
	output logic signed [ELEM_WIDTH-1:0]     inv_r1c1,
	output logic signed [ELEM_WIDTH-1:0]     inv_r1c2,
	output logic signed [ELEM_WIDTH-1:0]     inv_r2c0,
	output logic signed [ELEM_WIDTH-1:0]     inv_r2c1,
	output logic signed [ELEM_WIDTH-1:0]     inv_r2c2,
	output logic                             singular,
	output logic                             overflow
);
	localparam int W        = ELEM_WIDTH;
	localparam int CW       = 2 * W + 1;
	localparam int DW       = 3 * W + 3;
	localparam int PW       = 2 * W + 2;
	localparam int LANE_LAT = W + 3;
	localparam int TOTAL    = 5 + LANE_LAT;
	localparam bit ONE_FITS = (FRAC_BITS < W - 1);
	localparam logic [W-1:0] DIAG = ONE_FITS ? (W'(1) << FRAC_BITS) : {1'b0, {(W-1){1'b1}}};

	logic signed [W-1:0]  a_in [NUM_ELEM];
	logic signed [CW-1:0] cof_s2 [NUM_ELEM];
	logic signed [CW-1:0] cof_s3 [NUM_ELEM];
	logic signed [CW-1:0] cof_s4 [NUM_ELEM];
	logic signed [W-1:0]  a0_s1 [DIM];
	logic signed [W-1:0]  a0_s2 [DIM];
	logic signed [PW-1:0] pl_s3 [DIM];
	logic signed [PW-1:0] ph_s3 [DIM];
	logic signed [DW-1:0] det_s4;
	logic [CW-1:0]        mag_s5 [NUM_ELEM];
	logic                 neg_s5 [NUM_ELEM];
	logic [DW-1:0]        dmag_s5;
	logic                 zero_s5;
	logic signed [W-1:0]  lane_res [NUM_ELEM];
	logic [NUM_ELEM-1:0]  lane_ovf;
	logic [TOTAL-1:0]     vld_q;
	logic [LANE_LAT-1:0]  sing_q;
	logic signed [W-1:0]  inv_q [NUM_ELEM];
	logic                 done_q;
	logic                 singular_q;
	logic                 overflow_q;

	assign busy = 1'b0;

	assign a_in[0] = a_r0c0;
	assign a_in[1] = a_r0c1;
	assign a_in[2] = a_r0c2;
	assign a_in[3] = a_r1c0;
	assign a_in[4] = a_r1c1;
	assign a_in[5] = a_r1c2;
	assign a_in[6] = a_r2c0;
	assign a_in[7] = a_r2c1;
	assign a_in[8] = a_r2c2;

	m3i_cof #(.ELEM_WIDTH(ELEM_WIDTH)) u_cof (
		.clk (clk),
		.a   (a_in),
		.cof (cof_s2)
	);

	always_ff @(posedge clk) begin
		for (int c = 0; c < DIM; c++) begin
			a0_s1[c] <= a_in[c];
			a0_s2[c] <= a0_s1[c];
			pl_s3[c] <= PW'(a0_s2[c] * $signed({1'b0, cof_s2[c][W-1:0]}));
			ph_s3[c] <= PW'(a0_s2[c] * $signed(cof_s2[c][CW-1:W]));
		end
		for (int e = 0; e < NUM_ELEM; e++) begin
			cof_s3[e] <= cof_s2[e];
			cof_s4[e] <= cof_s3[e];
		end
	end

	always_ff @(posedge clk) begin
		det_s4 <= ((DW'(ph_s3[0]) <<< W) + DW'(pl_s3[0]))
		        + ((DW'(ph_s3[1]) <<< W) + DW'(pl_s3[1]))
		        + ((DW'(ph_s3[2]) <<< W) + DW'(pl_s3[2]));
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				mag_s5[idx(r, c)] <= cof_s4[idx(c, r)][CW-1] ? (CW'(0) - cof_s4[idx(c, r)])
				                                             : cof_s4[idx(c, r)];
				neg_s5[idx(r, c)] <= cof_s4[idx(c, r)][CW-1] ^ det_s4[DW-1];
			end
		end
		dmag_s5 <= det_s4[DW-1] ? (DW'(0) - det_s4) : det_s4;
		zero_s5 <= (det_s4 == '0);
	end

	genvar g;
	generate
		for (g = 0; g < NUM_ELEM; g++) begin : g_lane
			m3i_div_lane #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
				.clk     (clk),
				.num_mag (mag_s5[g]),
				.neg     (neg_s5[g]),
				.den_mag (dmag_s5),
				.res     (lane_res[g]),
				.ovf     (lane_ovf[g])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		sing_q <= {sing_q[LANE_LAT-2:0], zero_s5};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[TOTAL-2:0], start & ~busy};
			done_q <= vld_q[TOTAL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (sing_q[LANE_LAT-1]) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					inv_q[idx(r, c)] <= (r == c) ? $signed(DIAG) : '0;
				end
			end
			overflow_q <= ~ONE_FITS;
		end else begin
			for (int e = 0; e < NUM_ELEM; e++) begin
				inv_q[e] <= lane_res[e];
			end
			overflow_q <= |lane_ovf;
		end
		singular_q <= sing_q[LANE_LAT-1];
	end

	assign done     = done_q;
	assign singular = singular_q;
	assign overflow = overflow_q;
	assign inv_r0c0 = inv_q[0];
	assign inv_r0c1 = inv_q[1];
	assign inv_r0c2 = inv_q[2];
	assign inv_r1c0 = inv_q[3];
	assign inv_r1c1 = inv_q[4];
	assign inv_r1c2 = inv_q[5];
	assign inv_r2c0 = inv_q[6];
	assign inv_r2c1 = inv_q[7];
	assign inv_r2c2 = inv_q[8];
endmodule
`default_nettype wire
